// File: sv/stramp_pkg.sv
// shared types, codes and constants for the servo timed ramp unit
package stramp_pkg;

    localparam int MAX_ANGLE_DEF = 180;
    localparam int TIME_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam int ANGLE_W     = 8;
    localparam int REQ_TIME_W  = 16;
    localparam int FUNC_W      = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOVE_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOVE_TIME = 1'd1;

    localparam logic [CFG_W-1:0] MAX_TIME_RESET = 16'd5000;
    localparam logic [CFG_W-1:0] MIN_TIME_RESET = 16'd0;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 2'd0,
        FN_MOVE   = 2'd1,
        FN_SET    = 2'd2,
        FN_UNUSED = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_MOVE,
        OP_SET,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic                  axis;
        logic [ANGLE_W-1:0]    target;
        logic [REQ_TIME_W-1:0] dur;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } t_back_state;

endpackage

// File: sv/servo_timed_ramp_unit.sv
// top level of the two-axis servo timed ramp unit
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata axis,target_angle,move_time; tuser func
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata pan,tilt,moving,status
//  cfg       in   i_cfg_we (no wait)                 i_cfg_addr, i_cfg_wdata
//
//  one result per input item; a ramping tick steps the back end through exec, multiply,
//  8 restoring-divide steps one quotient bit each, and emit; any other item through exec and emit
//  the front register is registered ahead of the queue and keeps taking items while the
//  two-entry queue has room, so input and output stall independently
//  synchronous active-low reset puts both axes at 0, no move running, config at defaults
//  config writes take effect on the next item; nothing is held off by them
module servo_timed_ramp_unit #(
    parameter int MAX_ANGLE = stramp_pkg::MAX_ANGLE_DEF,
    parameter int TIME_BITS = stramp_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [stramp_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [stramp_pkg::CFG_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [0] axis, [8:1] target_angle, [24:9] move_time, [31:25] zero
    input  logic [stramp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] func
    input  logic [stramp_pkg::FUNC_W-1:0]      i_s_axis_tuser,
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [7:0] pan_drive, [15:8] tilt_drive, [16] moving, [17] status, [23:18] zero
    output logic [stramp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import stramp_pkg::*;

    localparam logic [ANGLE_W-1:0] MAX_A = ANGLE_W'(MAX_ANGLE);

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue to back
    logic pop;
    logic q_empty;
    t_cmd pop_cmd;

    // classify and clamp, hold config
    stramp_front #(
        .MAX_ANGLE (MAX_ANGLE),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_full          (q_full)
    );

    // decouples the front transfer from the back-end sequencer
    stramp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (pop_cmd)
    );

    // servo state, ramp arithmetic, result register
    stramp_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_cmd           (pop_cmd),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // queue is never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("command queue overflow");

    // a rejected command also stops any move
    a_reject_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[17]) |-> !o_m_axis_tdata[16])
        else $error("move still running after rejected command");

    // ramp never leaves the legal angle range
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] <= MAX_A)
                            && (o_m_axis_tdata[15:8] <= MAX_A))
        else $error("servo angle out of range");

endmodule

// File: sv/stramp_front.sv
// front end: config registers, input register, command classification and clamping
module stramp_front #(
    parameter int MAX_ANGLE = stramp_pkg::MAX_ANGLE_DEF,
    parameter int TIME_BITS = stramp_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stramp_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [stramp_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [stramp_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [stramp_pkg::FUNC_W-1:0]    i_s_axis_tuser,
    output logic                             o_push,
    output stramp_pkg::t_cmd                 o_cmd,
    input  logic                             i_full
);
    import stramp_pkg::*;

    localparam logic [ANGLE_W-1:0] MAX_A = ANGLE_W'(MAX_ANGLE);
    // requested time is cut to the time counter width before clamping
    localparam logic [REQ_TIME_W-1:0] REQ_MASK =
        (TIME_BITS >= REQ_TIME_W) ? '1 : REQ_TIME_W'((1 << TIME_BITS) - 1);

    logic [CFG_W-1:0]      r_max_time;
    logic [CFG_W-1:0]      r_min_time;
    logic                  r_valid;
    t_cmd                  r_cmd;

    t_func                 func_c;
    logic                  axis_c;
    logic [ANGLE_W-1:0]    target_c;
    logic [REQ_TIME_W-1:0] req_c;
    logic [REQ_TIME_W-1:0] dur_c;
    logic [31:0]           dur_ext;
    logic                  dur_zero;
    logic                  bad_angle;
    logic                  s_xfer;
    t_cmd                  cmd_c;

    assign func_c   = t_func'(i_s_axis_tuser);
    assign axis_c   = i_s_axis_tdata[0];
    assign target_c = i_s_axis_tdata[8:1];
    assign req_c    = i_s_axis_tdata[24:9] & REQ_MASK;

    // when the two cross, a request above max gets max and any other gets min
    always_comb begin
        if (req_c > r_max_time) begin
            dur_c = r_max_time;
        end else if (req_c < r_min_time) begin
            dur_c = r_min_time;
        end else begin
            dur_c = req_c;
        end
    end

    assign dur_ext   = 32'(dur_c);
    assign dur_zero  = (dur_ext[TIME_BITS-1:0] == '0);
    assign bad_angle = (target_c > MAX_A);

    always_comb begin
        cmd_c.axis   = axis_c;
        cmd_c.target = target_c;
        cmd_c.dur    = dur_c;
        unique case (func_c)
            FN_TICK: cmd_c.op = OP_TICK;
            FN_MOVE: begin
                // a move that clamps to zero lands at once
                if (bad_angle) begin
                    cmd_c.op = OP_REJECT;
                end else if (dur_zero) begin
                    cmd_c.op = OP_SET;
                end else begin
                    cmd_c.op = OP_MOVE;
                end
            end
            FN_SET:  cmd_c.op = bad_angle ? OP_REJECT : OP_SET;
            default: cmd_c.op = OP_NOP;
        endcase
    end

    assign o_s_axis_tready = !r_valid || !i_full;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid && !i_full;
    assign o_cmd           = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_time <= MAX_TIME_RESET;
            r_min_time <= MIN_TIME_RESET;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MAX_MOVE_TIME: r_max_time <= i_cfg_wdata;
                    CFG_MIN_MOVE_TIME: r_min_time <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_xfer) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_cmd <= cmd_c;
        end
    end

endmodule

// File: sv/stramp_fifo.sv
// short command queue between front and back
module stramp_fifo #(
    parameter int DEPTH = stramp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stramp_pkg::t_cmd i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output stramp_pkg::t_cmd o_cmd
);
    import stramp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: sv/stramp_back.sv
// back end: servo state, ramp multiply, restoring divide and result register
module stramp_back #(
    parameter int TIME_BITS = stramp_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_empty,
    input  stramp_pkg::t_cmd                   i_cmd,
    output logic                               o_pop,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [stramp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import stramp_pkg::*;

    localparam int PW = TIME_BITS + ANGLE_W;

    t_back_state          r_state;
    t_back_state          n_state;
    t_cmd                 r_cmd;
    logic [ANGLE_W-1:0]   r_pan;
    logic [ANGLE_W-1:0]   r_tilt;
    logic [ANGLE_W-1:0]   r_start;
    logic [ANGLE_W-1:0]   r_goal;
    logic                 r_axis;
    logic                 r_active;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_dur;
    logic [PW-1:0]        r_rem;
    logic [ANGLE_W-1:0]   r_quo;
    logic [2:0]           r_bit;
    logic                 r_neg;
    logic                 r_status;
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                 emit_go;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic                 tick_done;
    logic                 ramp_tick;
    logic [31:0]          dur_ext;
    logic [TIME_BITS-1:0] cmd_dur;
    logic [ANGLE_W-1:0]   delta_mag;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        trial;
    logic                 fits;
    logic [ANGLE_W-1:0]   n_quo;
    logic [ANGLE_W-1:0]   ramp_angle;

    assign elapsed_inc = r_elapsed + TIME_BITS'(1);
    assign tick_done   = (elapsed_inc >= r_dur);
    assign ramp_tick   = (r_cmd.op == OP_TICK) && r_active && !tick_done;
    assign dur_ext     = 32'(r_cmd.dur);
    assign cmd_dur     = dur_ext[TIME_BITS-1:0];

    assign delta_mag = (r_goal >= r_start) ? (r_goal - r_start) : (r_start - r_goal);
    assign prod      = PW'(delta_mag) * PW'(r_elapsed);
    assign trial     = PW'(r_dur) << r_bit;
    assign fits      = (r_rem >= trial);

    always_comb begin
        n_quo        = r_quo;
        n_quo[r_bit] = fits;
    end

    assign ramp_angle = r_neg ? (r_start - n_quo) : (r_start + n_quo);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_EXEC;
            ST_EXEC: n_state = ramp_tick ? ST_MUL : ST_EMIT;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (r_bit == 3'd0) n_state = ST_EMIT;
            ST_EMIT: if (emit_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop   = (r_state == ST_IDLE) && !i_empty;
        emit_go = (r_state == ST_EMIT) && (!r_out_valid || i_m_axis_tready);
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pan       <= '0;
            r_tilt      <= '0;
            r_start     <= '0;
            r_goal      <= '0;
            r_axis      <= 1'b0;
            r_active    <= 1'b0;
            r_elapsed   <= '0;
            r_dur       <= '0;
            r_status    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                r_status <= (r_cmd.op == OP_REJECT);
                case (r_cmd.op)
                    OP_TICK: begin
                        if (r_active) begin
                            r_elapsed <= elapsed_inc;
                            if (tick_done) begin
                                r_active <= 1'b0;
                                if (r_axis) r_tilt <= r_goal;
                                else        r_pan  <= r_goal;
                            end
                        end
                    end
                    OP_MOVE: begin
                        r_active  <= 1'b1;
                        r_axis    <= r_cmd.axis;
                        r_start   <= r_cmd.axis ? r_tilt : r_pan;
                        r_goal    <= r_cmd.target;
                        r_elapsed <= '0;
                        r_dur     <= cmd_dur;
                    end
                    OP_SET: begin
                        r_active <= 1'b0;
                        if (r_cmd.axis) r_tilt <= r_cmd.target;
                        else            r_pan  <= r_cmd.target;
                    end
                    OP_REJECT: r_active <= 1'b0;
                    default: ;
                endcase
            end
            if ((r_state == ST_DIV) && (r_bit == 3'd0)) begin
                if (r_axis) r_tilt <= ramp_angle;
                else        r_pan  <= ramp_angle;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_MUL) begin
            r_rem <= prod;
            r_neg <= (r_goal < r_start);
            r_quo <= '0;
            r_bit <= 3'd7;
        end
        if (r_state == ST_DIV) begin
            r_rem <= fits ? (r_rem - trial) : r_rem;
            r_quo <= n_quo;
            r_bit <= r_bit - 3'd1;
        end
        if (emit_go) begin
            r_out_data <= {6'd0, r_status, r_active, r_tilt, r_pan};
        end
    end

endmodule

// File: tb/testbench.sv
// self-checking testbench for the servo timed ramp unit: stream driver, monitor, ramp predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stramp_pkg::*;

    localparam int IDLE_LIMIT  = 4000;  // cycles with no transfer on either side
    localparam int LONG_HOLD   = 300;   // receiver hold-off, well past the input queue depth
    localparam int SETTLE_WAIT = 30;    // margin after the last result, a few ramp ticks worth
    localparam int REPORT_MAX  = 10;

    typedef struct {
        t_func              func;
        logic               axis;
        logic [ANGLE_W-1:0] target;
        logic [15:0]        move_time;
    } t_servo_cmd;

    typedef struct {
        logic [ANGLE_W-1:0] pan;
        logic [ANGLE_W-1:0] tilt;
        logic               moving;
        logic               status;
    } t_servo_drive;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // every block input starts at a known value
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = CFG_MAX_MOVE_TIME;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data    = '0;
    logic [FUNC_W-1:0]      s_user    = FN_TICK;
    logic                   m_ready   = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;

    servo_timed_ramp_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // [0] axis, [8:1] target_angle, [24:9] move_time, [31:25] zero
        .i_s_axis_tdata  (s_data),
        // [1:0] func
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [7:0] pan_drive, [15:8] tilt_drive, [16] moving, [17] status, [23:18] zero
        .o_m_axis_tdata  (m_data)
    );

    // ---------------------------------------------------------------
    // ramp predictor: own copy of the axis state and the move limits
    // ---------------------------------------------------------------
    logic [ANGLE_W-1:0] pred_pan     = '0;
    logic [ANGLE_W-1:0] pred_tilt    = '0;
    logic [ANGLE_W-1:0] ramp_start   = '0;
    logic [ANGLE_W-1:0] ramp_goal    = '0;
    logic               ramp_axis    = 1'b0;
    logic               ramp_busy    = 1'b0;
    logic [15:0]        ramp_elapsed = '0;
    logic [15:0]        ramp_length  = '0;
    logic [15:0]        limit_max    = MAX_TIME_RESET;
    logic [15:0]        limit_min    = MIN_TIME_RESET;

    // a time above max becomes max, otherwise below min becomes min
    function automatic logic [15:0] clamp_duration(logic [15:0] req);
        if (req > limit_max)
            return limit_max;
        if (req < limit_min)
            return limit_min;
        return req;
    endfunction

    function automatic void place_axis(logic ax, logic [ANGLE_W-1:0] angle);
        if (ax)
            pred_tilt = angle;
        else
            pred_pan = angle;
    endfunction

    function automatic t_servo_drive advance_servo(t_servo_cmd c);
        t_servo_drive d;
        longint       span;
        longint       frac;
        logic [15:0]  dur;
        d.status = 1'b0;
        case (c.func) inside
            FN_TICK: begin
                if (ramp_busy) begin
                    ramp_elapsed = ramp_elapsed + 16'd1;
                    if (ramp_elapsed >= ramp_length || ramp_length == 16'd0) begin
                        // end of the move lands exactly on the goal
                        place_axis(ramp_axis, ramp_goal);
                        ramp_busy = 1'b0;
                    end else begin
                        // signed division truncates toward zero, also for falling ramps
                        span = longint'(ramp_goal) - longint'(ramp_start);
                        frac = (span * longint'(ramp_elapsed)) / longint'(ramp_length);
                        place_axis(ramp_axis, ANGLE_W'(longint'(ramp_start) + frac));
                    end
                end
            end
            FN_MOVE, FN_SET: begin
                // any command, rejected or not, stops a running move
                ramp_busy = 1'b0;
                if (int'(c.target) > MAX_ANGLE_DEF) begin
                    d.status = 1'b1;
                end else if (c.func == FN_SET) begin
                    place_axis(c.axis, c.target);
                end else begin
                    dur = clamp_duration(c.move_time);
                    if (dur == 16'd0) begin
                        place_axis(c.axis, c.target);
                    end else begin
                        ramp_axis    = c.axis;
                        ramp_start   = c.axis ? pred_tilt : pred_pan;
                        ramp_goal    = c.target;
                        ramp_elapsed = 16'd0;
                        ramp_length  = dur;
                        ramp_busy    = 1'b1;
                    end
                end
            end
            default: ;  // unused selector leaves everything alone
        endcase
        d.pan    = pred_pan;
        d.tilt   = pred_tilt;
        d.moving = ramp_busy;
        return d;
    endfunction

    // ---------------------------------------------------------------
    // shared queues and run control
    // ---------------------------------------------------------------
    t_servo_cmd   pending_cmds[$];
    t_servo_drive expected_drives[$];
    t_servo_cmd   offered_cmd;
    int           error_count    = 0;
    int           idle_cycles    = 0;
    bit           quiet_tail     = 1'b0;  // no idling on either side
    bit           long_hold_req  = 1'b0;
    int           send_gap       = 0;
    int           recv_gap       = 0;
    int           hold_left      = 0;

    // ---------------------------------------------------------------
    // driver: offers pending commands, predicts on each input transfer
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_drives.push_back(advance_servo(offered_cmd));
            // valid may only change once the offered item has gone
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 12);
                    s_valid  <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= {7'd0, offered_cmd.move_time, offered_cmd.target,
                                offered_cmd.axis};
                    s_user  <= offered_cmd.func;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each result transfer against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_servo_drive want;
        t_servo_drive got;
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.pan    = m_data[7:0];
                got.tilt   = m_data[15:8];
                got.moving = m_data[16];
                got.status = m_data[17];
                if (expected_drives.size() == 0) begin
                    if (error_count < REPORT_MAX)
                        $display("%0t: unexpected result pan %0d tilt %0d mv %0b st %0b",
                                 $realtime, got.pan, got.tilt, got.moving, got.status);
                    error_count++;
                end else begin
                    want = expected_drives.pop_front();
                    if (got.pan !== want.pan || got.tilt !== want.tilt ||
                        got.moving !== want.moving || got.status !== want.status) begin
                        if (error_count < REPORT_MAX)
                            $display("%0t: mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                     $realtime, want.pan, want.tilt, want.moving,
                                     want.status, got.pan, got.tilt, got.moving,
                                     got.status);
                        error_count++;
                    end
                end
            end
            // long hold-off lets the input side back up and stall
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left <= LONG_HOLD;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(1, 12);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic void push_cmd(t_func f, logic ax, int tgt, int mt);
        t_servo_cmd c;
        c.func      = f;
        c.axis      = ax;
        c.target    = ANGLE_W'(tgt);
        c.move_time = 16'(mt);
        pending_cmds.push_back(c);
    endfunction

    // mostly complete ramps (move then enough ticks), the rest noise and interruptions
    task automatic queue_ramp_traffic(int n);
        int          sent;
        int          tgt;
        int          mt;
        int          span;
        int          ticks;
        int          pick;
        logic [15:0] dur;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 9);
                tgt  = (pick == 0) ? 0 : (pick == 1) ? MAX_ANGLE_DEF : $urandom_range(0, 180);
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    mt = $urandom_range(0, 24);
                else if (pick < 17)
                    mt = $urandom_range(0, 65535);
                else
                    mt = int'(pick[0] ? limit_max : limit_min) + $urandom_range(0, 2) - 1;
                if (mt < 0)
                    mt = 0;
                dur = clamp_duration(16'(mt));
                span = (dur > 16'd40) ? 40 : int'(dur);
                // now and then cut the ramp short
                ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span)
                                                    : span + $urandom_range(0, 2);
                push_cmd(FN_MOVE, 1'($urandom_range(0, 1)), tgt, mt);
                sent++;
                repeat (ticks) begin
                    push_cmd(FN_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                             $urandom_range(0, 65535));
                    sent++;
                end
            end else begin
                pick = $urandom_range(0, 7);
                if (pick == 0) begin
                    // ignored selector, does not count
                    push_cmd(FN_UNUSED, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                             $urandom_range(0, 65535));
                end else begin
                    push_cmd(t_func'(2'($urandom_range(0, 2))), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 255), $urandom_range(0, 65535));
                    sent++;
                end
            end
        end
    endtask

    // sender pauses until every predicted result has come back
    // sampled at the falling edge so the driver and monitor updates have settled
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_valid || expected_drives.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // written only while the block is idle
    task automatic write_move_limits(logic [15:0] max_t, logic [15:0] min_t);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAX_MOVE_TIME;
        cfg_wdata <= max_t;
        @(posedge i_clk);
        cfg_addr  <= CFG_MIN_MOVE_TIME;
        cfg_wdata <= min_t;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        limit_max = max_t;
        limit_min = min_t;
    endtask

    task automatic run_phase(logic [15:0] max_t, logic [15:0] min_t, int n);
        write_move_limits(max_t, min_t);
        queue_ramp_traffic(n);
        wait_for_drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset limits
        push_cmd(FN_TICK, 1'b0, 0, 0);            // tick with no move running
        push_cmd(FN_SET, 1'b0, 180, 0);
        push_cmd(FN_SET, 1'b1, 255, 65535);       // rejected angle
        push_cmd(FN_SET, 1'b1, 181, 0);           // just past the limit
        push_cmd(FN_SET, 1'b1, 180, 0);
        push_cmd(FN_MOVE, 1'b0, 0, 4);            // falling ramp to completion
        repeat (4) push_cmd(FN_TICK, 1'b0, 0, 0);
        push_cmd(FN_TICK, 1'b1, 255, 65535);      // idle again
        push_cmd(FN_MOVE, 1'b1, 7, 3);            // fraction truncates toward zero
        repeat (2) push_cmd(FN_TICK, 1'b0, 0, 0);
        push_cmd(FN_MOVE, 1'b0, 100, 0);          // zero duration lands at once
        push_cmd(FN_MOVE, 1'b1, 50, 65535);       // clamped to the max
        push_cmd(FN_TICK, 1'b0, 0, 0);
        push_cmd(FN_MOVE, 1'b1, 200, 5);          // rejected command still stops the move
        push_cmd(FN_TICK, 1'b0, 0, 0);
        push_cmd(FN_MOVE, 1'b0, 10, 2);
        push_cmd(FN_TICK, 1'b0, 0, 0);
        push_cmd(FN_SET, 1'b1, 90, 0);            // set during a move
        push_cmd(FN_TICK, 1'b0, 0, 0);
        push_cmd(FN_UNUSED, 1'b1, 255, 65535);    // ignored selector
        push_cmd(FN_MOVE, 1'b0, 180, 1);
        push_cmd(FN_TICK, 1'b0, 0, 0);
        queue_ramp_traffic(80);
        wait_for_drain();

        // input backs up behind a long receiver hold-off
        long_hold_req = 1'b1;
        run_phase(16'd12, 16'd4, 140);
        run_phase(16'd3, 16'd7, 90);              // min above max
        run_phase(16'd65535, 16'd65535, 60);
        run_phase(16'd1, 16'd0, 100);
        run_phase(16'd65535, 16'd0, 110);

        quiet_tail = 1'b1;
        run_phase(16'd20, 16'd2, 90);

        error_count += expected_drives.size();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: servo_timed_ramp_unit.f
sv/stramp_pkg.sv
sv/stramp_front.sv
sv/stramp_fifo.sv
sv/stramp_back.sv
sv/servo_timed_ramp_unit.sv
tb/testbench.sv
